// File: hw/rtl/aba_pkg.sv
package aba_pkg;

  // block geometry, fixed by the 18-bit granted size field
  localparam int BLOCK_BYTES     = 1024;
  localparam int BLOCK_LOG       = 10;
  localparam int DEF_NUM_BLOCKS  = 128;

  // field widths
  localparam int ADDR_W    = 32;
  localparam int BYTES_W   = 18;
  localparam int CODE_W    = 4;
  localparam int POOL_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int NEED_W    = ADDR_W + 1 - BLOCK_LOG;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BLOCKS = 1'b1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_UNKNOWN   = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_DECODE   = 12'b0000_0000_0100,
    S_ROUND    = 12'b0000_0000_1000,
    S_BOUND    = 12'b0000_0001_0000,
    S_RD       = 12'b0000_0010_0000,
    S_CHK      = 12'b0000_0100_0000,
    S_MARK     = 12'b0000_1000_0000,
    S_FREE_RD  = 12'b0001_0000_0000,
    S_FREE_CHK = 12'b0010_0000_0000,
    S_CLR_RUN  = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_t;

endpackage

// File: hw/rtl/aligned_bitmap_block_allocator_unit.sv
// Allocator for a pool of up to NUM_BLOCKS blocks of 1024 bytes each. An
// allocate rounds the request up to a power-of-two run of blocks, aligned to
// the run size in absolute byte addresses, and grants the lowest free run
// that fits in the pool; a free must name the start of a live allocation.
// After reset a clearing pass empties the block map; no request is taken
// during it. Each request is worked one at a time by a small sequencer
// around a single-port block map with one read and one write per cycle:
// an allocate runs decode, a rounding step per doubling, a check of each
// candidate run against the pool end, a read and a check per block examined
// and a mark per block marked, or ends after decode if larger than the pool;
// a free runs decode, a map read, a check and a release per block released,
// or ends after decode if the address is rejected. The result stage holds for
// as long as the last result waits to be taken; the next request waits too.
module aligned_bitmap_block_allocator_unit #(
  parameter int NUM_BLOCKS = aba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [aba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aba_pkg::ADDR_W-1:0]    cfg_data,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,  // request_bytes, free_address
  input  logic                          in_tuser,  // kind
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [55:0]                   out_tdata, // grant_address, grant_bytes
  output logic [1:0]                    out_tuser  // status
);
  import aba_pkg::*;

  localparam int NB_W  = $clog2(NUM_BLOCKS);
  localparam int RUN_W = NB_W + 1;
  localparam int CW    = NB_W + 2;

  // block map storage
  logic              used_mem [NUM_BLOCKS];
  logic [CODE_W-1:0] code_mem [NUM_BLOCKS];
  logic              rd_used_r;
  logic [CODE_W-1:0] rd_code_r;

  state_t            state_r, state_nxt;
  logic              kind_r, kind_nxt;
  logic [ADDR_W-1:0] req_r, req_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [CW-1:0]     cand_r, cand_nxt;
  logic [CW-1:0]     need_r, need_nxt;
  logic [NB_W-1:0]   ptr_r, ptr_nxt;
  logic [RUN_W-1:0]  cnt_r, cnt_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [CODE_W-1:0] lg_r, lg_nxt;
  status_t           st_r, st_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [BYTES_W-1:0] out_bytes_r, out_bytes_nxt;

  logic [ADDR_W-1:0] pool_base_r;
  logic [POOL_W-1:0] pool_blocks_r;

  // derived values
  logic [CW-1:0]     total;
  logic [ADDR_W:0]   need_sum;
  logic [NEED_W-1:0] need_full;
  logic [NEED_W-1:0] need_one;
  logic [ADDR_W-1:0] diff;
  logic [ADDR_W-BLOCK_LOG-1:0] idx_full;
  logic [ADDR_W-1:0] neg_base;
  logic [RUN_W-1:0]  run_m1;
  logic [NB_W-1:0]   first_cand;
  logic              bound_ok;
  logic              last_free;
  logic              wr_en;
  logic              wr_used;
  logic [CODE_W-1:0] wr_code;
  logic              grant;

  // pool size clamped to the map depth
  assign total = ({24'd0, pool_blocks_r} > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS)
                                                            : CW'(pool_blocks_r);

  // blocks needed, at least one
  assign need_sum  = {1'b0, req_r} + (ADDR_W + 1)'(BLOCK_BYTES - 1);
  assign need_full = need_sum[ADDR_W:BLOCK_LOG];
  assign need_one  = (need_full == '0) ? NEED_W'(1) : need_full;

  // free address decode
  assign diff     = faddr_r - pool_base_r;
  assign idx_full = diff[ADDR_W-1:BLOCK_LOG];

  // first aligned candidate: (-base mod run size) in blocks
  assign neg_base   = ADDR_W'(0) - pool_base_r;
  assign run_m1     = run_r - RUN_W'(1);
  assign first_cand = neg_base[BLOCK_LOG+NB_W-1:BLOCK_LOG] & run_m1[NB_W-1:0];

  assign bound_ok  = (cand_r + CW'(run_r)) <= total;
  assign last_free = (cnt_r == run_m1) || (ptr_r == NB_W'(NUM_BLOCKS - 1));
  assign grant     = (st_r == ST_OK) && (kind_r == KIND_ALLOC);

  // map write port
  always_comb begin
    wr_en   = (state_r == S_CLEAR) || (state_r == S_MARK) || (state_r == S_CLR_RUN);
    wr_used = (state_r == S_MARK);
    wr_code = ((state_r == S_MARK) && (cnt_r == '0)) ? (lg_r + CODE_W'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[ptr_r] <= wr_used;
      code_mem[ptr_r] <= wr_code;
    end
    rd_used_r <= used_mem[ptr_r];
    rd_code_r <= code_mem[ptr_r];
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    req_nxt        = req_r;
    faddr_nxt      = faddr_r;
    cand_nxt       = cand_r;
    need_nxt       = need_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    run_nxt        = run_r;
    lg_nxt         = lg_r;
    st_nxt         = st_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    unique case (state_r)
      S_CLEAR: begin
        if (ptr_r == NB_W'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + NB_W'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          req_nxt   = in_tdata[31:0];
          faddr_nxt = in_tdata[63:32];
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (kind_r == KIND_ALLOC) begin
          if (need_one > NEED_W'(total)) begin
            st_nxt    = ST_TOO_LARGE;
            state_nxt = S_RESP;
          end else begin
            need_nxt  = CW'(need_one);
            run_nxt   = RUN_W'(1);
            lg_nxt    = '0;
            state_nxt = S_ROUND;
          end
        end else if ((faddr_r < pool_base_r) || (diff[BLOCK_LOG-1:0] != '0) ||
                     (idx_full >= (ADDR_W-BLOCK_LOG)'(NUM_BLOCKS))) begin
          st_nxt    = ST_UNKNOWN;
          state_nxt = S_RESP;
        end else begin
          ptr_nxt   = idx_full[NB_W-1:0];
          state_nxt = S_FREE_RD;
        end
      end
      // one doubling per cycle up to the needed run
      S_ROUND: begin
        if (CW'(run_r) < need_r) begin
          run_nxt = run_r << 1;
          lg_nxt  = lg_r + CODE_W'(1);
        end else if (CW'(run_r) > total) begin
          st_nxt    = ST_TOO_LARGE;
          state_nxt = S_RESP;
        end else begin
          cand_nxt  = CW'(first_cand);
          state_nxt = S_BOUND;
        end
      end
      S_BOUND: begin
        if (bound_ok) begin
          ptr_nxt   = cand_r[NB_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_RD;
        end else begin
          st_nxt    = ST_NO_SPACE;
          state_nxt = S_RESP;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      // one block of the candidate run per visit
      S_CHK: begin
        if (rd_used_r) begin
          cand_nxt  = cand_r + CW'(run_r);
          state_nxt = S_BOUND;
        end else if (cnt_r == run_m1) begin
          ptr_nxt   = cand_r[NB_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_MARK;
        end else begin
          ptr_nxt   = ptr_r + NB_W'(1);
          cnt_nxt   = cnt_r + RUN_W'(1);
          state_nxt = S_RD;
        end
      end
      S_MARK: begin
        if (cnt_r == run_m1) begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end else begin
          ptr_nxt = ptr_r + NB_W'(1);
          cnt_nxt = cnt_r + RUN_W'(1);
        end
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (rd_code_r == '0) begin
          st_nxt    = ST_UNKNOWN;
          state_nxt = S_RESP;
        end else begin
          run_nxt   = RUN_W'(1) << (rd_code_r - CODE_W'(1));
          cnt_nxt   = '0;
          state_nxt = S_CLR_RUN;
        end
      end
      // release the run, stopping at the end of the map
      S_CLR_RUN: begin
        if (last_free) begin
          st_nxt    = ST_OK;
          state_nxt = S_RESP;
        end else begin
          ptr_nxt = ptr_r + NB_W'(1);
          cnt_nxt = cnt_r + RUN_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_addr_nxt   = grant ? (pool_base_r + (ADDR_W'(cand_r) << BLOCK_LOG)) : '0;
          out_bytes_nxt  = grant ? BYTES_W'(ADDR_W'(run_r) << BLOCK_LOG) : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    faddr_r      <= faddr_nxt;
    cand_r       <= cand_nxt;
    need_r       <= need_nxt;
    cnt_r        <= cnt_nxt;
    run_r        <= run_nxt;
    lg_r         <= lg_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bytes_r  <= out_bytes_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      pool_blocks_r <= POOL_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POOL_BASE:   pool_base_r   <= cfg_data;
        REG_POOL_BLOCKS: pool_blocks_r <= cfg_data[POOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_bytes_r, out_addr_r};

endmodule

// File: tb/aligned_bitmap_block_allocator_unit_tb.sv
`timescale 1ns / 100ps

module aligned_bitmap_block_allocator_unit_tb;
  import aba_pkg::*;

  localparam int NUM_BLOCKS = DEF_NUM_BLOCKS;
  // longest quiet stretch: clearing pass, a long output hold and a full-pool scan, with margin
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] grant_address;
    logic [BYTES_W-1:0] grant_bytes;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;   // request_bytes, free_address
  logic in_tuser;          // kind
  logic out_tvalid;
  logic out_tready;
  logic [55:0] out_tdata;  // grant_address, grant_bytes
  logic [1:0] out_tuser;   // status

  // mirror of the allocator state and its registers
  logic [ADDR_W-1:0] cur_base = '0;
  logic [POOL_W-1:0] cur_blocks = 8'd128;
  bit blk_taken [NUM_BLOCKS];
  bit [CODE_W-1:0] run_code [NUM_BLOCKS];

  grant_t pending_grants [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int n_alloc = 0;
  int n_free = 0;
  int n_settings = 1;
  int status_seen [4];

  aligned_bitmap_block_allocator_unit #(.NUM_BLOCKS(NUM_BLOCKS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocate: round up to a power-of-two run, take the lowest free aligned run in the pool
  function automatic grant_t grant_for_request(input logic [31:0] req);
    longint unsigned total, need, run, run_bytes, first_blk, i, j, addr64;
    int unsigned lg;
    bit busy;
    grant_t r;
    r.status = ST_TOO_LARGE;
    r.grant_address = '0;
    r.grant_bytes = '0;
    total = (cur_blocks > NUM_BLOCKS) ? NUM_BLOCKS : cur_blocks;
    need = ({32'd0, req} + BLOCK_BYTES - 1) / BLOCK_BYTES;
    if (need == 0) need = 1;
    if (need > total) return r;
    run = 1;
    lg = 0;
    while (run < need) begin
      run = run << 1;
      lg++;
    end
    if (run > total) return r;
    run_bytes = run * BLOCK_BYTES;
    // first candidate aligned to the run size in absolute addresses
    first_blk = ((run_bytes - ({32'd0, cur_base} % run_bytes)) % run_bytes) / BLOCK_BYTES;
    r.status = ST_NO_SPACE;
    for (i = first_blk; i + run <= total; i += run) begin
      busy = 1'b0;
      for (j = 0; j < run; j++)
        if (blk_taken[i + j]) busy = 1'b1;
      if (!busy) begin
        for (j = 0; j < run; j++) blk_taken[i + j] = 1'b1;
        run_code[i] = CODE_W'(lg + 1);
        addr64 = cur_base + i * BLOCK_BYTES;
        r.status = ST_OK;
        r.grant_address = addr64[ADDR_W-1:0];
        r.grant_bytes = run_bytes[BYTES_W-1:0];
        return r;
      end
    end
    return r;
  endfunction

  // free: must name the start of a live run, relative to the current base
  function automatic grant_t release_outcome(input logic [31:0] addr);
    logic [31:0] diff;
    int unsigned idx, stop, k;
    grant_t r;
    r.status = ST_UNKNOWN;
    r.grant_address = '0;
    r.grant_bytes = '0;
    if (addr < cur_base) return r;
    diff = addr - cur_base;
    if (diff % BLOCK_BYTES != 0) return r;
    if (diff / BLOCK_BYTES >= NUM_BLOCKS) return r;
    idx = diff / BLOCK_BYTES;
    if (run_code[idx] == 0) return r;
    stop = idx + (1 << (run_code[idx] - 1));
    if (stop > NUM_BLOCKS) stop = NUM_BLOCKS;
    for (k = idx; k < stop; k++) blk_taken[k] = 1'b0;
    run_code[idx] = '0;
    r.status = ST_OK;
    return r;
  endfunction

  // request size, mostly a few blocks, now and then large or zero
  function automatic logic [31:0] alloc_bytes();
    int unsigned lg, pick, blocks;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 32'd0;
    if (pick < 75) lg = $urandom_range(0, 2);
    else if (pick < 95) lg = $urandom_range(3, 5);
    else lg = $urandom_range(6, 7);
    blocks = (lg == 0) ? 1 : $urandom_range((1 << (lg - 1)) + 1, 1 << lg);
    return (blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
  endfunction

  // address of a random live run start, or noise when nothing is live
  function automatic logic [31:0] live_start_addr();
    int unsigned starts [$];
    for (int k = 0; k < NUM_BLOCKS; k++)
      if (run_code[k] != 0) starts.push_back(k);
    if (starts.size() == 0) return $urandom;
    return cur_base + starts[$urandom_range(0, starts.size() - 1)] * BLOCK_BYTES;
  endfunction

  // offer one request, with random idle beforehand; valid stays high on return
  task automatic send_request(input logic kind, input logic [31:0] req_bytes,
                              input logic [31:0] rel_addr);
    grant_t r;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {rel_addr, req_bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_ALLOC) begin
      r = grant_for_request(req_bytes);
      n_alloc++;
    end else begin
      r = release_outcome(rel_addr);
      n_free++;
    end
    status_seen[r.status]++;
    pending_grants.push_back(r);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  // write both pool registers, only while nothing is outstanding
  task automatic set_pool(input logic [31:0] base, input logic [7:0] blocks);
    cfg_we <= 1'b1;
    cfg_index <= REG_POOL_BASE;
    cfg_data <= base;
    @(posedge clk);
    cur_base = base;
    cfg_index <= REG_POOL_BLOCKS;
    cfg_data <= {{(ADDR_W-POOL_W){1'b0}}, blocks};
    @(posedge clk);
    cur_blocks = blocks;
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) send_request(KIND_ALLOC, alloc_bytes(), $urandom);
    else if (pick < 80) send_request(KIND_FREE, $urandom, live_start_addr());
    else if (pick < 85) send_request(KIND_ALLOC, $urandom, $urandom);
    else if (pick < 90) send_request(KIND_FREE, $urandom, $urandom);
    else if (pick < 95)
      send_request(KIND_FREE, $urandom, live_start_addr() + $urandom_range(1, BLOCK_BYTES - 1));
    else
      send_request(KIND_FREE, $urandom, live_start_addr() + BLOCK_BYTES * $urandom_range(1, 3));
  endtask

  // rounding, alignment and the size limits under the reset settings
  task automatic test_alloc_rounding();
    send_request(KIND_ALLOC, 32'd0, 32'd0);
    send_request(KIND_ALLOC, 32'd1, 32'd0);
    send_request(KIND_ALLOC, 32'd1025, 32'd0);
    send_request(KIND_ALLOC, 32'd3 * BLOCK_BYTES, 32'd0);
    send_request(KIND_ALLOC, 32'd131073, 32'd0);
    send_request(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC, 32'd131072, 32'd0);
    wait_all_results();
  endtask

  // bad and good frees, then the whole pool in one run
  task automatic test_free_checks();
    send_request(KIND_FREE, 32'd0, 32'h0000_0401);
    send_request(KIND_FREE, 32'd0, 32'd0);
    send_request(KIND_FREE, 32'd0, 32'd0);
    send_request(KIND_FREE, 32'd0, NUM_BLOCKS * BLOCK_BYTES);
    send_request(KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_FREE, 32'd0, 32'd5 * BLOCK_BYTES);
    send_request(KIND_FREE, 32'd0, 32'd1 * BLOCK_BYTES);
    send_request(KIND_FREE, 32'd0, 32'd2 * BLOCK_BYTES);
    send_request(KIND_FREE, 32'd0, 32'd4 * BLOCK_BYTES);
    send_request(KIND_ALLOC, 32'd131072, 32'd0);
    send_request(KIND_FREE, 32'd0, 32'd0);
    wait_all_results();
  endtask

  // empty pool, clamped pool, address wrap, unaligned base, runs left live across changes
  task automatic test_pool_registers();
    set_pool(32'h0000_0400, 8'd0);
    send_request(KIND_ALLOC, 32'd0, 32'd0);
    send_request(KIND_FREE, 32'd0, 32'd0);
    wait_all_results();
    set_pool(32'hFFFF_FC00, 8'd255);
    send_request(KIND_ALLOC, 32'd4096, 32'd0);
    wait_all_results();
    set_pool(32'h0000_0123, 8'd2);
    send_request(KIND_ALLOC, 32'd2048, 32'd0);
    send_request(KIND_ALLOC, 32'd1, 32'd0);
    wait_all_results();
    set_pool(32'h0000_0000, 8'd1);
    send_request(KIND_FREE, 32'd0, 32'd1 * BLOCK_BYTES);
    send_request(KIND_FREE, 32'd0, 32'h0000_0123);
    wait_all_results();
  endtask

  // mixed traffic under one pool setting and one idling pattern
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct,
                                     input logic [31:0] base, input logic [7:0] blocks,
                                     input bit pause_mid);
    wait_all_results();
    set_pool(base, blocks);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) wait_all_results();
      send_random_item();
    end
    wait_all_results();
  endtask

  // long output hold while requests keep coming, so the input backs up
  task automatic test_output_backpressure();
    wait_all_results();
    set_pool(32'h0000_0000, 8'd128);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = LONG_HOLD;
    for (int n = 0; n < 16; n++) send_random_item();
    wait_all_results();
  endtask

  // output ready: random stalls, or a long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // compare each result transaction with the oldest expected grant
  always @(posedge clk) begin
    grant_t exp_g;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d addr %h bytes %h", $time,
                 out_tuser, out_tdata[31:0], out_tdata[49:32]);
        mismatch_count++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (out_tuser !== exp_g.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_g.status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[31:0] !== exp_g.grant_address) begin
          $display("%0t: grant_address expected %h actual %h", $time, exp_g.grant_address,
                   out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[49:32] !== exp_g.grant_bytes) begin
          $display("%0t: grant_bytes expected %h actual %h", $time, exp_g.grant_bytes,
                   out_tdata[49:32]);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               quiet_cycles, pending_grants.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_alloc_rounding();
    test_free_checks();
    test_pool_registers();
    test_random_traffic(150, 0, 0, 32'h0000_0000, 8'd128, 1'b0);
    test_random_traffic(150, 80, 0, 32'h0000_0C00, 8'd128, 1'b1);
    test_random_traffic(150, 0, 80, {$urandom} & 32'hFFFF_FC00, 8'($urandom_range(1, 128)),
                        1'b0);
    test_random_traffic(150, 35, 35, 32'hFFFF_8000, 8'd128, 1'b0);
    test_output_backpressure();
    test_random_traffic(150, 0, 0, $urandom, 8'($urandom_range(1, 16)), 1'b0);
    test_random_traffic(150, 35, 35, 32'h0000_0000, 8'd1, 1'b0);
    test_random_traffic(150, 80, 0, 32'hFFFF_FFFF, 8'($urandom_range(129, 255)), 1'b0);
    test_random_traffic(150, 0, 80, {$urandom} & 32'hFFFF_FC00, 8'd64, 1'b0);

    // let any stray result show up
    recv_stall_pct = 0;
    repeat (200) @(posedge clk);

    $display("covered %0d allocates and %0d frees over %0d pool settings", n_alloc, n_free,
             n_settings);
    $display("outcomes: %0d ok, %0d too large, %0d no space, %0d unknown address",
             status_seen[ST_OK], status_seen[ST_TOO_LARGE], status_seen[ST_NO_SPACE],
             status_seen[ST_UNKNOWN]);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: aligned_bitmap_block_allocator_unit.f
hw/rtl/aba_pkg.sv
hw/rtl/aligned_bitmap_block_allocator_unit.sv
tb/aligned_bitmap_block_allocator_unit_tb.sv
